### src/prefix_code_bit_packer_top_assert.svh
// assertion macros for the prefix code bit packer
// used by modules that need clk and arst_n in scope
`ifndef PREFIX_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define PREFIX_CODE_BIT_PACKER_TOP_ASSERT_SVH

// property that must hold whenever the block is out of reset
`define PCBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define PCBP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PCBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pcbp_pkg.sv
// shared types and constants for the prefix code bit packer
// no dependencies
`timescale 1ns / 1ps

package pcbp_pkg;

	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int ENTRY_W      = LEN_W + CODE_W;
	localparam int SYM_W        = 8;
	localparam int OP_W         = 2;
	localparam int QUEUE_DEPTH  = 4;

	localparam int MAX_CODE_LEN_DEFAULT = 32;
	localparam int SYMBOL_COUNT_DEFAULT = 256;

	// operation codes; code 3 is ignored
	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	// one job handed from front to back
	typedef struct packed {
		logic              is_flush;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;   // left aligned, first bit at msb
	} job_t;

	// back end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_ENC
	} back_state_t;

endpackage

### src/pcbp_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/pcbp_front.sv
// front end: takes commands, owns the code table, turns encodes and flushes into jobs
// depends on pcbp_pkg and pcbp_ram
`timescale 1ns / 1ps

module pcbp_front #(
	parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEFAULT,
	parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [pcbp_pkg::OP_W-1:0]     op,
	input  logic [pcbp_pkg::SYM_W-1:0]    symbol,
	input  logic [pcbp_pkg::LEN_W-1:0]    code_length,
	input  logic [pcbp_pkg::CODE_W-1:0]   code_bits,
	output logic                          push,
	output pcbp_pkg::job_t                push_job,
	input  logic                          queue_full
);

	localparam int AW = $clog2(SYMBOL_COUNT);
	localparam int LIMIT = (MAX_CODE_LEN < pcbp_pkg::CODE_W) ? MAX_CODE_LEN : pcbp_pkg::CODE_W;
	localparam logic [pcbp_pkg::LEN_W-1:0] LEN_LIMIT = pcbp_pkg::LEN_W'(LIMIT);
	localparam logic [pcbp_pkg::SYM_W:0] SYM_END = (pcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);

	logic                              accept;
	logic                              in_range;
	logic                              is_load;
	logic                              is_encode;
	logic                              is_flush;
	logic [pcbp_pkg::LEN_W-1:0]        len_sat;
	logic                              wr_en;
	logic                              rd_en;
	logic [pcbp_pkg::ENTRY_W-1:0]      rd_data;
	logic [pcbp_pkg::LEN_W-1:0]        rd_len;
	logic [pcbp_pkg::CODE_W-1:0]       rd_code;
	logic                              valid_s1;
	logic                              flush_s1;
	logic                              push_needed;
	logic                              done_s1;

	// decode the incoming command
	assign accept    = cmd_valid && !cmd_stall;
	assign in_range  = {1'b0, symbol} < SYM_END;
	assign is_load   = op == pcbp_pkg::OP_LOAD;
	assign is_encode = op == pcbp_pkg::OP_ENCODE;
	assign is_flush  = op == pcbp_pkg::OP_FLUSH;
	assign len_sat   = (code_length > LEN_LIMIT) ? LEN_LIMIT : code_length;
	assign wr_en     = accept && is_load && in_range;
	assign rd_en     = accept && is_encode && in_range;

	// code table: length in the upper bits, code below
	pcbp_ram #(
		.WIDTH(pcbp_pkg::ENTRY_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(symbol[AW-1:0]),
		.wr_data({len_sat, code_bits}),
		.rd_en  (rd_en),
		.rd_addr(symbol[AW-1:0]),
		.rd_data(rd_data)
	);

	assign rd_len  = rd_data[pcbp_pkg::ENTRY_W-1:pcbp_pkg::CODE_W];
	assign rd_code = rd_data[pcbp_pkg::CODE_W-1:0];

	// table read stage: a job moves on once the queue has room
	assign push_needed = flush_s1 || (rd_len != '0);
	assign done_s1     = valid_s1 && (!push_needed || !queue_full);
	assign cmd_stall   = valid_s1 && push_needed && queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (is_encode && in_range) || is_flush;
			flush_s1 <= is_flush;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// left align the code so its first bit sits at the msb
	always_comb begin
		push              = valid_s1 && push_needed && !queue_full;
		push_job.is_flush = flush_s1;
		push_job.len      = rd_len;
		push_job.code     = rd_code << (pcbp_pkg::LEN_W'(pcbp_pkg::CODE_W) - rd_len);
	end

endmodule

### src/pcbp_queue.sv
// short job queue between front and back end
// depends on pcbp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "prefix_code_bit_packer_top_assert.svh"

module pcbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcbp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output pcbp_pkg::job_t pop_job,
	output logic           empty
);

	localparam int PW = $clog2(pcbp_pkg::QUEUE_DEPTH);

	pcbp_pkg::job_t  slot_q [pcbp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = count_q == (PW + 1)'(pcbp_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PCBP_ASSERT(a_no_overflow, !(push && full), "job pushed into a full queue")
	`PCBP_ASSERT(a_no_underflow, !(pop && empty), "job popped from an empty queue")

endmodule

### src/pcbp_back.sv
// back end: packs code bits into bytes and drives the output register
// depends on pcbp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "prefix_code_bit_packer_top_assert.svh"

module pcbp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  pcbp_pkg::job_t               pop_job,
	output logic                         pop,
	output logic                         byte_valid,
	input  logic                         byte_stall,
	output logic [7:0]                   out_byte,
	output logic                         last
);

	pcbp_pkg::back_state_t        state_q;
	pcbp_pkg::back_state_t        state_d;
	logic [7:0]                   partial_q;
	logic [2:0]                   bitpos_q;
	logic [pcbp_pkg::CODE_W-1:0]  code_q;
	logic [pcbp_pkg::LEN_W-1:0]   rem_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         last_q;

	logic                         out_free;
	logic [3:0]                   avail;
	logic [3:0]                   take;
	logic [7:0]                   partial_new;
	logic                         byte_done;
	logic                         load_job;
	logic                         step;
	logic                         do_flush;
	logic                         emit;
	logic [7:0]                   emit_byte;
	logic                         emit_last;

	assign out_free = !out_valid_q || !byte_stall;

	// one packing step: fill the partial byte from the top of the code
	always_comb begin
		avail       = {1'b0, bitpos_q} + 4'd1;
		take        = (rem_q < pcbp_pkg::LEN_W'(avail)) ? rem_q[3:0] : avail;
		partial_new = partial_q | (code_q[pcbp_pkg::CODE_W-1 -: 8] >> (3'd7 - bitpos_q));
		byte_done   = take == avail;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_job  = 1'b0;
		step      = 1'b0;
		do_flush  = 1'b0;
		emit      = 1'b0;
		emit_byte = partial_new;
		emit_last = 1'b0;
		unique case (state_q)
			pcbp_pkg::BK_IDLE: begin
				if (!empty) begin
					if (!pop_job.is_flush) begin
						pop      = 1'b1;
						load_job = 1'b1;
						state_d  = pcbp_pkg::BK_ENC;
					end else if (out_free) begin
						pop       = 1'b1;
						do_flush  = bitpos_q != 3'd7;
						emit      = do_flush;
						emit_byte = partial_q;
						emit_last = 1'b1;
					end
				end
			end
			pcbp_pkg::BK_ENC: begin
				if (!byte_done || out_free) begin
					step = 1'b1;
					emit = byte_done;
					if (rem_q == pcbp_pkg::LEN_W'(take)) begin
						state_d = pcbp_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = pcbp_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcbp_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// accumulator and current code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 8'd0;
			bitpos_q  <= 3'd7;
			rem_q     <= '0;
		end else if (load_job) begin
			rem_q <= pop_job.len;
		end else if (do_flush) begin
			partial_q <= 8'd0;
			bitpos_q  <= 3'd7;
		end else if (step) begin
			rem_q <= rem_q - pcbp_pkg::LEN_W'(take);
			if (byte_done) begin
				partial_q <= 8'd0;
				bitpos_q  <= 3'd7;
			end else begin
				partial_q <= partial_new;
				bitpos_q  <= bitpos_q - take[2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			code_q <= pop_job.code;
		end else if (step) begin
			code_q <= code_q << take;
		end
	end

	// output register, takes a new byte whenever the old one is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;

	`PCBP_ASSERT_IMPL(a_empty_acc_clear, bitpos_q == 3'd7, partial_q == 8'd0, "partial byte not clear")
	`PCBP_ASSERT_IMPL(a_enc_has_bits, state_q == pcbp_pkg::BK_ENC, rem_q != '0, "encoding with no bits left")
	`PCBP_ASSERT_NEXT(a_emit_lands, emit, out_valid_q, "emitted byte did not reach the output")

endmodule

### src/prefix_code_bit_packer_top.sv
// top level of the prefix code bit packer
// depends on pcbp_pkg, pcbp_front, pcbp_queue and pcbp_back
`timescale 1ns / 1ps

// Usage: commands enter on cmd_valid/cmd_stall with op, symbol, code_length
// and code_bits. A load (op 0) writes the code table entry of symbol; an encode
// (op 1) appends the symbol's code bits, first bit at the msb of each byte;
// a flush (op 2) sends a pending partial byte, zero padded, with last set.
// Bytes leave on byte_valid/byte_stall with out_byte and last.
// An encode passes the table read stage, then the packer picks up the job and
// packs it chunk by chunk, a chunk being the bits up to the next byte boundary:
// a code of L bits needs at most ceil(L/8)+1 chunks, so five for a 32-bit code.
// The packer shifts at most one byte per cycle into the output register, while
// the held byte is not stalled, which sets the throughput. A four-entry job
// queue lets commands keep arriving while the packer works. A byte passes the
// table read stage, the job queue and the packer into the output register.
// Reset clears the accumulator (bit position back to the msb), the queue and
// the output register; the code table keeps no reset and must be loaded
// before use. When byte_stall is high the held byte stays, the packer stops
// once it has a byte to emit, the queue fills and cmd_stall rises.
module prefix_code_bit_packer_top #(
	parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEFAULT,
	parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic [pcbp_pkg::OP_W-1:0]   op,
	input  logic [pcbp_pkg::SYM_W-1:0]  symbol,
	input  logic [pcbp_pkg::LEN_W-1:0]  code_length,
	input  logic [pcbp_pkg::CODE_W-1:0] code_bits,
	output logic                        byte_valid,
	input  logic                        byte_stall,
	output logic [7:0]                  out_byte,
	output logic                        last
);

	logic           push;
	pcbp_pkg::job_t push_job;
	logic           queue_full;
	logic           pop;
	pcbp_pkg::job_t pop_job;
	logic           queue_empty;

	// command intake and table
	pcbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.op         (op),
		.symbol     (symbol),
		.code_length(code_length),
		.code_bits  (code_bits),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	// job queue
	pcbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (queue_full),
		.pop     (pop),
		.pop_job (pop_job),
		.empty   (queue_empty)
	);

	// bit packer and output register
	pcbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (queue_empty),
		.pop_job   (pop_job),
		.pop       (pop),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

### dv/prefix_code_bit_packer_checker.sv
// transfer monitor and byte predictor for the prefix code bit packer
// depends on pcbp_pkg; instantiated beside the block by prefix_code_bit_packer_top_test
`timescale 1ns / 1ps

module prefix_code_bit_packer_checker #(
	parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  logic                        cmd_stall,
	input  logic [pcbp_pkg::OP_W-1:0]   op,
	input  logic [pcbp_pkg::SYM_W-1:0]  symbol,
	input  logic [pcbp_pkg::LEN_W-1:0]  code_length,
	input  logic [pcbp_pkg::CODE_W-1:0] code_bits,
	input  logic                        byte_valid,
	input  logic                        byte_stall,
	input  logic [7:0]                  out_byte,
	input  logic                        last,
	output int                          mismatches,
	output int                          outstanding
);
	import pcbp_pkg::*;

	// longest code the table keeps, capped by the code field width
	localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [2:0] MSB_POS = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	packed_byte_t      expected_bytes [$];
	logic [LEN_W-1:0]  code_len_tbl [256];
	logic [CODE_W-1:0] code_val_tbl [256];
	logic [7:0]        acc_byte;
	logic [2:0]        fill_pos;

	// append code bits msb first, queueing every byte that fills up
	task automatic pack_code(input logic [LEN_W-1:0] n_bits, input logic [CODE_W-1:0] code);
		for (int i = n_bits; i > 0; i--) begin
			if (code[5'(i - 1)])
				acc_byte[fill_pos] = 1'b1;
			if (fill_pos == 3'd0) begin
				expected_bytes.push_back(packed_byte_t'{data: acc_byte, last: 1'b0});
				acc_byte = 8'd0;
				fill_pos = MSB_POS;
			end else begin
				fill_pos = fill_pos - 3'd1;
			end
		end
	endtask

	// compare byte transfers, then predict from command transfers
	always @(posedge clk or negedge arst_n) begin
		packed_byte_t     want;
		logic [LEN_W-1:0] n_bits;
		if (!arst_n) begin
			for (int k = 0; k < 256; k++) begin
				code_len_tbl[k[7:0]] = '0;
				code_val_tbl[k[7:0]] = '0;
			end
			expected_bytes.delete();
			acc_byte = 8'd0;
			fill_pos = MSB_POS;
			mismatches = 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte %02h last %b", $time, out_byte, last);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.data, out_byte);
						mismatches++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %b actual %b", $time, want.last, last);
						mismatches++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				case (op)
					OP_LOAD: begin
						n_bits = (code_length > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : code_length;
						code_len_tbl[symbol] = n_bits;
						code_val_tbl[symbol] = code_bits;
					end
					OP_ENCODE: begin
						pack_code(code_len_tbl[symbol], code_val_tbl[symbol]);
					end
					OP_FLUSH: begin
						// only a pending partial byte goes out
						if (fill_pos != MSB_POS) begin
							expected_bytes.push_back(packed_byte_t'{data: acc_byte, last: 1'b1});
							acc_byte = 8'd0;
							fill_pos = MSB_POS;
						end
					end
					default: begin
					end
				endcase
			end
		end
		outstanding = expected_bytes.size();
	end

endmodule

### dv/prefix_code_bit_packer_top_test.sv
// stimulus and verdict for the prefix code bit packer
// depends on pcbp_pkg, prefix_code_bit_packer_top and prefix_code_bit_packer_checker
`timescale 1ns / 1ps

module prefix_code_bit_packer_top_test;
	import pcbp_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 470;
	localparam int IDLE_PCT = 29;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	logic [OP_W-1:0]   op;
	logic [SYM_W-1:0]  symbol;
	logic [LEN_W-1:0]  code_length;
	logic [CODE_W-1:0] code_bits;
	logic              byte_valid;
	logic              byte_stall;
	logic [7:0]        out_byte;
	logic              last;
	int                mismatches;
	int                outstanding;

	// shared control between sender and receiver
	bit                calm;
	bit                hold_request;

	// symbols with a loaded table entry, the only ones ever encoded
	bit                loaded [256];
	logic [SYM_W-1:0]  loaded_syms [$];

	prefix_code_bit_packer_top dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.op(op), .symbol(symbol), .code_length(code_length), .code_bits(code_bits),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.out_byte(out_byte), .last(last)
	);

	prefix_code_bit_packer_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.op(op), .symbol(symbol), .code_length(code_length), .code_bits(code_bits),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.out_byte(out_byte), .last(last),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one command transfer, with random idle cycles ahead of it
	task automatic issue(input logic [OP_W-1:0] kind, input logic [SYM_W-1:0] sym,
			input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid   <= 1'b1;
		op          <= kind;
		symbol      <= sym;
		code_length <= len;
		code_bits   <= bits;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] bits);
		issue(OP_LOAD, sym, len, bits);
		if (!loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	// unused fields carry random noise
	task automatic encode_sym(input logic [SYM_W-1:0] sym);
		issue(OP_ENCODE, sym, LEN_W'($urandom_range(63)), $urandom);
	endtask

	task automatic send_flush();
		issue(OP_FLUSH, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)), $urandom);
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return LEN_W'($urandom_range(8));
		else if (r < 80)
			return LEN_W'($urandom_range(16, 9));
		else if (r < 93)
			return LEN_W'($urandom_range(32, 17));
		else
			return LEN_W'($urandom_range(63, 33));
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		byte_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				byte_stall <= 1'b1;
				hold_left--;
			end else begin
				byte_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// reset, directed part, random part, drain and verdict
	initial begin
		int r;
		cmd_valid   = 1'b0;
		op          = OP_LOAD;
		symbol      = '0;
		code_length = '0;
		code_bits   = '0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty flush, unused op, table extremes
		send_flush();
		issue(OP_UNUSED, 8'hff, 6'h3f, 32'hffff_ffff);
		load_entry(8'd0, 6'd0, 32'hffff_ffff);
		load_entry(8'd255, 6'd32, 32'hffff_ffff);
		load_entry(8'd1, 6'd1, 32'h0000_0001);
		load_entry(8'd2, 6'd63, 32'ha5a5_3c3c);
		load_entry(8'd3, 6'd33, 32'h0000_0000);
		load_entry(8'd4, 6'd8, 32'h0000_00ab);
		load_entry(8'd128, 6'd3, 32'hffff_fffd);
		// zero length, single bit then flush, full 32-bit codes
		encode_sym(8'd0);
		encode_sym(8'd1);
		send_flush();
		encode_sym(8'd255);
		encode_sym(8'd2);
		// unaligned codes crossing byte boundaries
		encode_sym(8'd128);
		encode_sym(8'd1);
		encode_sym(8'd3);
		encode_sym(8'd4);
		send_flush();
		issue(OP_UNUSED, 8'h00, 6'h00, 32'h0000_0000);
		send_flush();

		// random part: mostly encodes of loaded symbols
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100)
				hold_request = 1'b1;
			calm = (n >= 180 && n < 260);
			if (n == 320) begin
				// sender pause until the output side has drained
				@(negedge clk);
				cmd_valid <= 1'b0;
				wait (outstanding == 0);
			end
			r = $urandom_range(99);
			if (r < 14)
				load_entry(SYM_W'($urandom_range(255)), pick_length(), $urandom);
			else if (r < 82)
				encode_sym(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
			else if (r < 94)
				send_flush();
			else
				issue(OP_UNUSED, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
					$urandom);
		end
		send_flush();
		calm = 1'b0;
		@(negedge clk);
		cmd_valid <= 1'b0;

		// drain, then let any stray byte show up
		wait (outstanding == 0);
		repeat (50) @(posedge clk);
		if (outstanding != 0)
			$display("%0t: %0d expected bytes never arrived", $time, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### prefix_code_bit_packer_top.f
+incdir+src
src/pcbp_pkg.sv
src/pcbp_ram.sv
src/pcbp_front.sv
src/pcbp_queue.sv
src/pcbp_back.sv
src/prefix_code_bit_packer_top.sv
dv/prefix_code_bit_packer_checker.sv
dv/prefix_code_bit_packer_top_test.sv
